FILE: rtl/wrk_pkg.sv
package wrk_pkg;

  // item and result beats
  typedef struct packed {
    logic signed [31:0] stance_angle;
    logic signed [31:0] stance_rate;
    logic signed [31:0] hip_angle;
    logic signed [31:0] hip_rate;
    logic signed [31:0] hip_torque;
    logic        [30:0] time_step;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_stance_angle;
    logic signed [31:0] new_stance_rate;
    logic signed [31:0] new_hip_angle;
    logic signed [31:0] new_hip_rate;
  } result_t;

  // context carried alongside the derivative evaluations
  typedef struct packed {
    logic signed [31:0] a1;
    logic signed [31:0] r1;
    logic signed [31:0] b1;
    logic signed [31:0] q1;
    logic signed [31:0] tq;
    logic        [30:0] dt;
    logic        [28:0] h6;
    logic signed [34:0] sum_ks;
    logic signed [34:0] sum_kh;
    logic signed [34:0] sum_r;
    logic signed [34:0] sum_q;
    logic signed [31:0] est_r;
    logic signed [31:0] est_q;
  } ctx_t;

  // pipeline depths
  localparam int HORNER_STEPS = 7;
  localparam int TRIG_LAT     = 6 + 3 * HORNER_STEPS + 2;
  localparam int ACC_LAT      = TRIG_LAT + 3;
  localparam int TOTAL_LAT    = 4 * ACC_LAT + 11;

  // angle constants in Q.56
  localparam logic [60:0] PI_Q56      = 61'h3243F6A8885A309;
  localparam logic [60:0] TWO_PI_Q56  = 61'h6487ED5110B4612;
  localparam logic [60:0] FOUR_PI_Q56 = 61'hC90FDAA22168C24;
  localparam logic [60:0] HALF_PI_Q56 = 61'h1921FB54442D184;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // reciprocal of six for the sixth step
  localparam logic [31:0] DIV6_RECIP = 32'((64'd1 << 32) / 64'd6);

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > 40'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Q4.28 product back to Q4.28, rounding half up
  function automatic logic signed [35:0] rnd28(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd134217728;
    return $signed(t[63:28]);
  endfunction

  // sine series divisors, innermost first at the highest index
  function automatic logic [7:0] sin_div(input logic [2:0] i);
    logic [7:0] d;
    unique case (i)
      3'd0:    d = 8'd6;
      3'd1:    d = 8'd20;
      3'd2:    d = 8'd42;
      3'd3:    d = 8'd72;
      3'd4:    d = 8'd110;
      3'd5:    d = 8'd156;
      default: d = 8'd210;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] sin_recip(input logic [2:0] i);
    logic [31:0] m;
    unique case (i)
      3'd0:    m = 32'((64'd1 << 32) / 64'd6);
      3'd1:    m = 32'((64'd1 << 32) / 64'd20);
      3'd2:    m = 32'((64'd1 << 32) / 64'd42);
      3'd3:    m = 32'((64'd1 << 32) / 64'd72);
      3'd4:    m = 32'((64'd1 << 32) / 64'd110);
      3'd5:    m = 32'((64'd1 << 32) / 64'd156);
      default: m = 32'((64'd1 << 32) / 64'd210);
    endcase
    return m;
  endfunction

  // cosine series divisors
  function automatic logic [7:0] cos_div(input logic [2:0] i);
    logic [7:0] d;
    unique case (i)
      3'd0:    d = 8'd2;
      3'd1:    d = 8'd12;
      3'd2:    d = 8'd30;
      3'd3:    d = 8'd56;
      3'd4:    d = 8'd90;
      3'd5:    d = 8'd132;
      default: d = 8'd182;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] cos_recip(input logic [2:0] i);
    logic [31:0] m;
    unique case (i)
      3'd0:    m = 32'((64'd1 << 32) / 64'd2);
      3'd1:    m = 32'((64'd1 << 32) / 64'd12);
      3'd2:    m = 32'((64'd1 << 32) / 64'd30);
      3'd3:    m = 32'((64'd1 << 32) / 64'd56);
      3'd4:    m = 32'((64'd1 << 32) / 64'd90);
      3'd5:    m = 32'((64'd1 << 32) / 64'd132);
      default: m = 32'((64'd1 << 32) / 64'd182);
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/walker_rk4_step.sv
// Compass walker integrator: one fourth-order Runge-Kutta step per item.
// Input channel: raise start with a full state in item; the beat is taken at
// any rising edge with start high and busy low. busy is always low, so a new
// item may be presented every cycle, one item per cycle sustained.
// Output channel: done pulses for one cycle with the stepped state on result.
// The receiver has no way to hold results back; every done beat must be taken.
// Each of the four derivative evaluations goes through the sine/cosine units,
// where the range reduction and squaring take six stages, each of the seven
// series terms three and the final scaling two, and then through the stages
// that combine them; the stage updates and the final sum follow. The slope
// angle, held in slope, is written with cfg_we and cfg_data; the user must
// write it only while the pipeline is empty, as the block does not enforce it.
// Reset is synchronous: it clears slope to zero and drops every in-flight
// item so no done beat follows until new items are taken.
module walker_rk4_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  wrk_pkg::item_t       item,
  output logic                 done,
  output wrk_pkg::result_t     result,
  input  logic                 cfg_we,
  input  logic signed [31:0]   cfg_data
);

  logic signed [31:0]          slope;
  logic [wrk_pkg::TOTAL_LAT-1:0] vsr;
  wrk_pkg::item_t              in_r;
  logic [63:0]                 prod6;
  wrk_pkg::ctx_t               ctx_in [4];
  wrk_pkg::ctx_t               ctx_dl [4];
  logic signed [31:0]          sa_in [4];
  logic signed [31:0]          sr_in [4];
  logic signed [31:0]          ha_in [4];
  logic signed [31:0]          ks_o [4];
  logic signed [31:0]          kh_o [4];
  wrk_pkg::ctx_t               ctx0;
  wrk_pkg::ctx_t               f1_ctx, f2_ctx;
  wrk_pkg::ctx_t               f1_next;
  logic signed [63:0]          fp_a, fp_r, fp_b, fp_q;

  assign busy = 1'b0;

  // slope register
  always_ff @(posedge clk) begin
    if (rst) begin
      slope <= '0;
    end else if (cfg_we) begin
      slope <= cfg_data;
    end
  end

  // valid bits follow items through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vsr <= '0;
    end else begin
      vsr <= {vsr[wrk_pkg::TOTAL_LAT-2:0], start & ~busy};
    end
  end

  assign done = vsr[wrk_pkg::TOTAL_LAT-1];

  // input beat and sixth step reciprocal product
  logic [31:0] v0;
  assign v0 = 32'(item.time_step) + 32'd3;

  always_ff @(posedge clk) begin
    in_r  <= item;
    prod6 <= 64'(v0) * 64'(wrk_pkg::DIV6_RECIP);
  end

  // sixth step correction and initial context
  logic [31:0] v1, q6;
  logic        c6;
  assign v1 = 32'(in_r.time_step) + 32'd3;
  assign q6 = prod6[63:32];
  assign c6 = ((35'(q6) + 35'd1) * 35'd6) <= 35'(v1);

  always_ff @(posedge clk) begin
    ctx0.a1     <= in_r.stance_angle;
    ctx0.r1     <= in_r.stance_rate;
    ctx0.b1     <= in_r.hip_angle;
    ctx0.q1     <= in_r.hip_rate;
    ctx0.tq     <= in_r.hip_torque;
    ctx0.dt     <= in_r.time_step;
    ctx0.h6     <= 29'(q6 + 32'(c6));
    ctx0.sum_ks <= '0;
    ctx0.sum_kh <= '0;
    ctx0.sum_r  <= 35'(in_r.stance_rate);
    ctx0.sum_q  <= 35'(in_r.hip_rate);
    ctx0.est_r  <= in_r.stance_rate;
    ctx0.est_q  <= in_r.hip_rate;
  end

  assign ctx_in[0] = ctx0;
  assign sa_in[0]  = ctx0.a1;
  assign sr_in[0]  = ctx0.r1;
  assign ha_in[0]  = ctx0.b1;

  // four derivative evaluations with stage updates between them
  for (genvar k = 0; k < 4; k++) begin : g_eval
    wrk_accel u_accel (
      .clk    (clk),
      .sa     (sa_in[k]),
      .sr     (sr_in[k]),
      .ha     (ha_in[k]),
      .slope  (slope),
      .torque (ctx_in[k].tq),
      .ks     (ks_o[k]),
      .kh     (kh_o[k])
    );

    wrk_delay #(.WIDTH($bits(wrk_pkg::ctx_t)), .DEPTH(wrk_pkg::ACC_LAT)) u_ctx (
      .clk (clk),
      .d   (ctx_in[k]),
      .q   (ctx_dl[k])
    );

    if (k < 3) begin : g_upd
      localparam bit KS_TWICE  = (k != 0);
      localparam bit EST_TWICE = (k != 2);

      wrk_pkg::ctx_t      u1_ctx, u2_ctx;
      wrk_pkg::ctx_t      u1_next, u2_next;
      logic signed [63:0] pr, pq, pa, pb;
      logic signed [31:0] hstep;
      logic signed [31:0] nr, nq, na, nb;
      logic signed [31:0] sa_r, sr_r, ha_r;

      // half step for the middle stages, full step for the last
      assign hstep = (k == 2) ? $signed({1'b0, ctx_dl[k].dt})
                              : $signed({2'b0, ctx_dl[k].dt[30:1]});

      // derivative sums
      always_comb begin
        u1_next        = ctx_dl[k];
        u1_next.sum_ks = ctx_dl[k].sum_ks + 35'(ks_o[k])
                         + (KS_TWICE ? 35'(ks_o[k]) : 35'sd0);
        u1_next.sum_kh = ctx_dl[k].sum_kh + 35'(kh_o[k])
                         + (KS_TWICE ? 35'(kh_o[k]) : 35'sd0);
      end

      always_ff @(posedge clk) begin
        pr     <= hstep * ks_o[k];
        pq     <= hstep * kh_o[k];
        pa     <= hstep * ctx_dl[k].est_r;
        pb     <= hstep * ctx_dl[k].est_q;
        u1_ctx <= u1_next;
      end

      // next stage estimates
      assign nr = wrk_pkg::sat32(40'(u1_ctx.r1) + 40'(wrk_pkg::rnd28(pr)));
      assign nq = wrk_pkg::sat32(40'(u1_ctx.q1) + 40'(wrk_pkg::rnd28(pq)));
      assign na = wrk_pkg::sat32(40'(u1_ctx.a1) + 40'(wrk_pkg::rnd28(pa)));
      assign nb = wrk_pkg::sat32(40'(u1_ctx.b1) + 40'(wrk_pkg::rnd28(pb)));

      always_comb begin
        u2_next       = u1_ctx;
        u2_next.est_r = nr;
        u2_next.est_q = nq;
        u2_next.sum_r = u1_ctx.sum_r + 35'(nr) + (EST_TWICE ? 35'(nr) : 35'sd0);
        u2_next.sum_q = u1_ctx.sum_q + 35'(nq) + (EST_TWICE ? 35'(nq) : 35'sd0);
      end

      always_ff @(posedge clk) begin
        u2_ctx <= u2_next;
        sa_r   <= na;
        sr_r   <= nr;
        ha_r   <= nb;
      end

      assign ctx_in[k+1] = u2_ctx;
      assign sa_in[k+1]  = sa_r;
      assign sr_in[k+1]  = sr_r;
      assign ha_in[k+1]  = ha_r;
    end
  end

  // last derivatives into the weighted sums
  always_comb begin
    f1_next        = ctx_dl[3];
    f1_next.sum_ks = ctx_dl[3].sum_ks + 35'(ks_o[3]);
    f1_next.sum_kh = ctx_dl[3].sum_kh + 35'(kh_o[3]);
  end

  always_ff @(posedge clk) begin
    f1_ctx <= f1_next;
  end

  // sixth step times weighted sums
  logic signed [29:0] h6s;
  assign h6s = $signed({1'b0, f1_ctx.h6});

  always_ff @(posedge clk) begin
    fp_a   <= 64'(h6s) * 64'(f1_ctx.sum_r);
    fp_r   <= 64'(h6s) * 64'(f1_ctx.sum_ks);
    fp_b   <= 64'(h6s) * 64'(f1_ctx.sum_q);
    fp_q   <= 64'(h6s) * 64'(f1_ctx.sum_kh);
    f2_ctx <= f1_ctx;
  end

  // result beat
  always_ff @(posedge clk) begin
    result.new_stance_angle <= wrk_pkg::sat32(40'(f2_ctx.a1) + 40'(wrk_pkg::rnd28(fp_a)));
    result.new_stance_rate  <= wrk_pkg::sat32(40'(f2_ctx.r1) + 40'(wrk_pkg::rnd28(fp_r)));
    result.new_hip_angle    <= wrk_pkg::sat32(40'(f2_ctx.b1) + 40'(wrk_pkg::rnd28(fp_b)));
    result.new_hip_rate     <= wrk_pkg::sat32(40'(f2_ctx.q1) + 40'(wrk_pkg::rnd28(fp_q)));
  end

endmodule

FILE: rtl/wrk_delay.sv
module wrk_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  // plain shift line
  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: rtl/wrk_trig.sv
module wrk_trig (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs
);

  logic        [32:0] mag1;
  logic               neg1;
  logic        [60:0] rem2;
  logic               neg2;
  logic        [57:0] m3;
  logic               neg3;
  logic        [57:0] m4;
  logic               neg4;
  logic               cneg4;
  logic signed [31:0] x5;
  logic               cneg5;
  logic signed [31:0] x6;
  logic               cneg6;
  logic        [31:0] x26;
  logic        [32:0] xc_d;
  logic        [31:0] x2_in [wrk_pkg::HORNER_STEPS+1];
  logic        [31:0] ts_in [wrk_pkg::HORNER_STEPS+1];
  logic        [31:0] tc_in [wrk_pkg::HORNER_STEPS+1];
  logic signed [63:0] xs7;
  logic signed [31:0] c7;

  // stage 1: difference and magnitude
  logic signed [32:0] arg;
  assign arg = 33'(a) - 33'(b);

  always_ff @(posedge clk) begin
    neg1 <= arg[32];
    mag1 <= arg[32] ? 33'(-arg) : 33'(arg);
  end

  // stage 2: remainder modulo two pi, quotient is at most two
  logic [60:0] m2w;
  logic [60:0] sub2;
  assign m2w = {mag1, 28'b0};

  always_comb begin
    if (m2w >= wrk_pkg::FOUR_PI_Q56) begin
      sub2 = wrk_pkg::FOUR_PI_Q56;
    end else if (m2w >= wrk_pkg::TWO_PI_Q56) begin
      sub2 = wrk_pkg::TWO_PI_Q56;
    end else begin
      sub2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    rem2 <= m2w - sub2;
    neg2 <= neg1;
  end

  // stage 3: wrap into minus pi to pi
  logic        over3;
  logic [60:0] w3;
  assign over3 = rem2 > wrk_pkg::PI_Q56;
  assign w3    = over3 ? (wrk_pkg::TWO_PI_Q56 - rem2) : rem2;

  always_ff @(posedge clk) begin
    m3   <= w3[57:0];
    neg3 <= neg2 ^ over3;
  end

  // stage 4: fold into minus half pi to half pi
  logic fold4;
  assign fold4 = 61'(m3) > wrk_pkg::HALF_PI_Q56;

  always_ff @(posedge clk) begin
    m4    <= fold4 ? (wrk_pkg::PI_Q56[57:0] - m3) : m3;
    cneg4 <= fold4;
    neg4  <= neg3;
  end

  // stage 5: round to Q.30
  logic signed [58:0] r5;
  logic signed [58:0] rr5;
  assign r5  = neg4 ? -$signed({1'b0, m4}) : $signed({1'b0, m4});
  assign rr5 = r5 + 59'sd33554432;

  always_ff @(posedge clk) begin
    x5    <= $signed(rr5[57:26]);
    cneg5 <= cneg4;
  end

  // stage 6: square
  logic signed [63:0] xx6;
  logic        [63:0] xr6;
  assign xx6 = x5 * x5;
  assign xr6 = $unsigned(xx6) + 64'd536870912;

  always_ff @(posedge clk) begin
    x26   <= xr6[61:30];
    x6    <= x5;
    cneg6 <= cneg5;
  end

  // x and fold flag wait for the series
  wrk_delay #(.WIDTH(33), .DEPTH(3 * wrk_pkg::HORNER_STEPS)) u_xdly (
    .clk (clk),
    .d   ({cneg6, x6}),
    .q   (xc_d)
  );

  assign x2_in[0] = x26;
  assign ts_in[0] = wrk_pkg::Q30_ONE;
  assign tc_in[0] = wrk_pkg::Q30_ONE;

  // horner steps, three stages each: product, reciprocal, correction
  for (genvar j = 0; j < wrk_pkg::HORNER_STEPS; j++) begin : g_step
    localparam logic [2:0]  IDX = 3'(wrk_pkg::HORNER_STEPS - 1 - j);
    localparam logic [7:0]  DS  = wrk_pkg::sin_div(IDX);
    localparam logic [7:0]  DC  = wrk_pkg::cos_div(IDX);
    localparam logic [31:0] MS  = wrk_pkg::sin_recip(IDX);
    localparam logic [31:0] MC  = wrk_pkg::cos_recip(IDX);

    logic [31:0] pa_s, pa_c, x2a;
    logic [63:0] pm_s, pm_c;
    logic [31:0] pb_s, pb_c, x2b;
    logic [31:0] tn_s, tn_c, x2c;
    logic [63:0] ms_s, ms_c;
    logic [31:0] q0_s, q0_c;
    logic        ck_s, ck_c;

    assign ms_s = 64'(x2_in[j]) * 64'(ts_in[j][30:0]) + 64'd536870912;
    assign ms_c = 64'(x2_in[j]) * 64'(tc_in[j][30:0]) + 64'd536870912;

    always_ff @(posedge clk) begin
      pa_s <= ms_s[61:30];
      pa_c <= ms_c[61:30];
      x2a  <= x2_in[j];
    end

    always_ff @(posedge clk) begin
      pm_s <= 64'(pa_s) * 64'(MS);
      pm_c <= 64'(pa_c) * 64'(MC);
      pb_s <= pa_s;
      pb_c <= pa_c;
      x2b  <= x2a;
    end

    assign q0_s = pm_s[63:32];
    assign q0_c = pm_c[63:32];
    assign ck_s = ((40'(q0_s) + 40'd1) * 40'(DS)) <= 40'(pb_s);
    assign ck_c = ((40'(q0_c) + 40'd1) * 40'(DC)) <= 40'(pb_c);

    always_ff @(posedge clk) begin
      tn_s <= wrk_pkg::Q30_ONE - (q0_s + 32'(ck_s));
      tn_c <= wrk_pkg::Q30_ONE - (q0_c + 32'(ck_c));
      x2c  <= x2b;
    end

    assign x2_in[j+1] = x2c;
    assign ts_in[j+1] = tn_s;
    assign tc_in[j+1] = tn_c;
  end

  // final scale and sign
  logic signed [31:0] tc7;
  assign tc7 = ($signed(tc_in[wrk_pkg::HORNER_STEPS]) + 32'sd2) >>> 2;

  always_ff @(posedge clk) begin
    xs7 <= $signed(xc_d[31:0]) * $signed(ts_in[wrk_pkg::HORNER_STEPS]);
    c7  <= xc_d[32] ? -tc7 : tc7;
  end

  logic signed [63:0] w8;
  logic signed [33:0] v8;
  assign w8 = xs7 + 64'sd536870912;
  assign v8 = $signed(w8[63:30]) + 34'sd2;

  always_ff @(posedge clk) begin
    sn <= $signed(v8[33:2]);
    cs <= c7;
  end

endmodule

FILE: rtl/wrk_accel.sv
module wrk_accel (
  input  logic               clk,
  input  logic signed [31:0] sa,
  input  logic signed [31:0] sr,
  input  logic signed [31:0] ha,
  input  logic signed [31:0] slope,
  input  logic signed [31:0] torque,
  output logic signed [31:0] ks,
  output logic signed [31:0] kh
);

  logic signed [31:0] st_sn, st_cs, hp_sn;
  logic signed [63:0] rr_prod;
  logic signed [31:0] tq1, tq2, rr2;
  logic        [63:0] side_d;
  logic signed [31:0] d1, s1, hs1, tqa;
  logic signed [63:0] prod2;
  logic signed [31:0] s2, tqb;

  // sine and cosine of stance minus slope
  wrk_trig u_stance (
    .clk (clk),
    .a   (sa),
    .b   (slope),
    .sn  (st_sn),
    .cs  (st_cs)
  );

  // sine of hip angle
  wrk_trig u_hip (
    .clk (clk),
    .a   (ha),
    .b   (32'sd0),
    .sn  (hp_sn),
    .cs  ()
  );

  // rate squared alongside the trig units
  always_ff @(posedge clk) begin
    rr_prod <= sr * sr;
    tq1     <= torque;
  end

  always_ff @(posedge clk) begin
    rr2 <= wrk_pkg::sat32(40'(wrk_pkg::rnd28(rr_prod)));
    tq2 <= tq1;
  end

  wrk_delay #(.WIDTH(64), .DEPTH(wrk_pkg::TRIG_LAT - 2)) u_side (
    .clk (clk),
    .d   ({tq2, rr2}),
    .q   (side_d)
  );

  // rate squared minus cosine
  always_ff @(posedge clk) begin
    d1  <= wrk_pkg::sat32(40'($signed(side_d[31:0])) - 40'(st_cs));
    s1  <= st_sn;
    hs1 <= hp_sn;
    tqa <= $signed(side_d[63:32]);
  end

  // hip sine times difference
  always_ff @(posedge clk) begin
    prod2 <= hs1 * d1;
    s2    <= s1;
    tqb   <= tqa;
  end

  // accelerations
  always_ff @(posedge clk) begin
    ks <= s2;
    kh <= wrk_pkg::sat32(40'(wrk_pkg::rnd28(prod2)) + 40'(s2) + 40'(tqb));
  end

endmodule

FILE: verif/walker_rk4_checker.sv
module walker_rk4_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  wrk_pkg::item_t   item,
  input  logic             done,
  input  wrk_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_data,
  output int               fail_count,
  output int               awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PI_Q     = 64'sh3243F6A8885A309;
  localparam longint TWO_PI_Q = 64'sh6487ED5110B4612;
  localparam longint HALF_PI_Q = 64'sh1921FB54442D184;
  localparam longint ONE_Q30  = 64'sd1 <<< 30;
  localparam longint S32_HI   = 64'sd2147483647;
  localparam longint S32_LO   = -64'sd2147483648;

  longint  slope;
  wrk_pkg::result_t expected_states[$];

  // clamp to the signed 32-bit range
  function automatic longint clamp32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  // arithmetic shift with rounding half up
  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return round_shift(a * b, 28);
  endfunction

  // sine and cosine of a Q4.28 angle via reduction, fold and series
  function automatic void sin_cos(input longint arg, output longint sn, output longint cs);
    longint sin_d[7];
    longint cos_d[7];
    longint a, r, x, x2, t;
    bit     flip;
    sin_d = '{6, 20, 42, 72, 110, 156, 210};
    cos_d = '{2, 12, 30, 56, 90, 132, 182};
    a = arg * (64'sd1 <<< 28);
    r = a - (a / TWO_PI_Q) * TWO_PI_Q;
    flip = 1'b0;
    if (r > PI_Q) r = r - TWO_PI_Q;
    else if (r < -PI_Q) r = r + TWO_PI_Q;
    if (r > HALF_PI_Q) begin
      r = PI_Q - r;
      flip = 1'b1;
    end else if (r < -HALF_PI_Q) begin
      r = -PI_Q - r;
      flip = 1'b1;
    end
    x  = round_shift(r, 26);
    x2 = round_shift(x * x, 30);
    t = ONE_Q30;
    for (int i = 6; i >= 0; i--) t = ONE_Q30 - round_shift(x2 * t, 30) / sin_d[i];
    sn = round_shift(round_shift(x * t, 30), 2);
    t = ONE_Q30;
    for (int i = 6; i >= 0; i--) t = ONE_Q30 - round_shift(x2 * t, 30) / cos_d[i];
    t = round_shift(t, 2);
    cs = flip ? -t : t;
  endfunction

  // walker accelerations at one state estimate
  function automatic void walker_accel(input longint sa, input longint sr, input longint ha,
                                       input longint torque, output longint acc_s,
                                       output longint acc_h);
    longint s, c, hs, hc, rr, d;
    sin_cos(sa - slope, s, c);
    sin_cos(ha, hs, hc);
    rr = clamp32(qmul(sr, sr));
    d = clamp32(rr - c);
    acc_s = clamp32(s);
    acc_h = clamp32(qmul(hs, d) + acc_s + torque);
  endfunction

  // one classical fourth-order step of the walker state
  function automatic wrk_pkg::result_t rk4_advance(input wrk_pkg::item_t it);
    longint a1, r1, b1, q1, tq, dt, h2, h6;
    longint ks1, kh1, ks2, kh2, ks3, kh3, ks4, kh4;
    longint a2, r2, b2, q2, a3, r3, b3, q3, a4, r4, b4, q4;
    wrk_pkg::result_t res;
    a1 = longint'(it.stance_angle);
    r1 = longint'(it.stance_rate);
    b1 = longint'(it.hip_angle);
    q1 = longint'(it.hip_rate);
    tq = longint'(it.hip_torque);
    dt = longint'({33'd0, it.time_step});
    h2 = dt >>> 1;
    h6 = (dt + 3) / 6;
    walker_accel(a1, r1, b1, tq, ks1, kh1);
    r2 = clamp32(r1 + qmul(h2, ks1));
    q2 = clamp32(q1 + qmul(h2, kh1));
    a2 = clamp32(a1 + qmul(h2, r1));
    b2 = clamp32(b1 + qmul(h2, q1));
    walker_accel(a2, r2, b2, tq, ks2, kh2);
    r3 = clamp32(r1 + qmul(h2, ks2));
    q3 = clamp32(q1 + qmul(h2, kh2));
    a3 = clamp32(a1 + qmul(h2, r2));
    b3 = clamp32(b1 + qmul(h2, q2));
    walker_accel(a3, r3, b3, tq, ks3, kh3);
    r4 = clamp32(r1 + qmul(dt, ks3));
    q4 = clamp32(q1 + qmul(dt, kh3));
    a4 = clamp32(a1 + qmul(dt, r3));
    b4 = clamp32(b1 + qmul(dt, q3));
    walker_accel(a4, r4, b4, tq, ks4, kh4);
    res.new_stance_rate  = 32'(clamp32(r1 + qmul(h6, ks1 + 2 * ks2 + 2 * ks3 + ks4)));
    res.new_hip_rate     = 32'(clamp32(q1 + qmul(h6, kh1 + 2 * kh2 + 2 * kh3 + kh4)));
    res.new_stance_angle = 32'(clamp32(a1 + qmul(h6, r1 + 2 * r2 + 2 * r3 + r4)));
    res.new_hip_angle    = 32'(clamp32(b1 + qmul(h6, q1 + 2 * q2 + 2 * q3 + q4)));
    return res;
  endfunction

  function automatic int field_ok(input string name, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      return 0;
    end
    return 1;
  endfunction

  assign awaited = expected_states.size();

  // track the slope, predict each taken item, check each result beat
  always @(posedge clk) begin
    wrk_pkg::result_t want;
    int ok;
    if (rst) begin
      slope = 0;
      expected_states.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) slope = longint'($signed(cfg_data));
      if (start && !busy) expected_states.push_back(rk4_advance(item));
      if (done) begin
        if (expected_states.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_states.pop_front();
          ok = field_ok("new_stance_angle", want.new_stance_angle, result.new_stance_angle)
             & field_ok("new_stance_rate", want.new_stance_rate, result.new_stance_rate)
             & field_ok("new_hip_angle", want.new_hip_angle, result.new_hip_angle)
             & field_ok("new_hip_rate", want.new_hip_rate, result.new_hip_rate);
          if (!ok) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 160;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  wrk_pkg::item_t   item = '0;
  logic             done;
  wrk_pkg::result_t result;
  logic             cfg_we = 1'b0;
  logic [31:0]      cfg_data = '0;
  int               fail_count;
  int               awaited;
  int               cycles = 0;

  always #5 clk = ~clk;

  walker_rk4_step DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  walker_rk4_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .awaited(awaited)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // mostly no gap, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  task automatic send_beat(input wrk_pkg::item_t it);
    int gap;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  task automatic write_slope(input logic [31:0] v);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a walker near its natural gait, small angles and steps
  function automatic wrk_pkg::item_t gait_item();
    wrk_pkg::item_t it;
    it.stance_angle = $signed(32'($urandom_range(600000000))) - 32'sd300000000;
    it.stance_rate  = $signed(32'($urandom_range(800000000))) - 32'sd400000000;
    it.hip_angle    = $signed(32'($urandom_range(1200000000))) - 32'sd600000000;
    it.hip_rate     = $signed(32'($urandom_range(1600000000))) - 32'sd800000000;
    it.hip_torque   = $signed(32'($urandom_range(60000000))) - 32'sd30000000;
    it.time_step    = 31'($urandom_range(30000000));
    return it;
  endfunction

  function automatic wrk_pkg::item_t noise_item();
    wrk_pkg::item_t it;
    it.stance_angle = $urandom;
    it.stance_rate  = $urandom;
    it.hip_angle    = $urandom;
    it.hip_rate     = $urandom;
    it.hip_torque   = $urandom;
    it.time_step    = 31'($urandom);
    return it;
  endfunction

  task automatic directed_items();
    wrk_pkg::item_t it;
    logic [31:0] ext[4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    // extremes of every field, with zero, tiny and full time steps
    for (int i = 0; i < 4; i++) begin
      it.stance_angle = ext[i];
      it.stance_rate  = ext[(i + 1) % 4];
      it.hip_angle    = ext[(i + 2) % 4];
      it.hip_rate     = ext[(i + 3) % 4];
      it.hip_torque   = ext[i];
      it.time_step    = 31'h7FFF_FFFF;
      send_beat(it);
      it.time_step    = '0;
      send_beat(it);
      it.time_step    = 31'd1;
      send_beat(it);
      it.time_step    = 31'd5;
      send_beat(it);
    end
    // angles around the fold points of the trig reduction
    it = gait_item();
    it.stance_angle = 32'sd421657428;
    it.hip_angle    = -32'sd843314857;
    send_beat(it);
    it.stance_angle = 32'sd843314857;
    it.hip_angle    = 32'sd1686629713;
    send_beat(it);
    // zero step on an ordinary state
    it = gait_item();
    it.time_step = '0;
    send_beat(it);
    // large but finite step
    it = gait_item();
    it.time_step = 31'h1000_0000;
    send_beat(it);
  endtask

  initial begin
    logic [31:0] slopes[6];
    slopes = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0055_0000,
               32'hFFAB_0000, 32'h0000_0000};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    for (int ph = 0; ph < 6; ph++) begin
      write_slope(ph == 5 ? $urandom : slopes[ph]);
      for (int n = 0; n < 205; n++) begin
        send_beat($urandom_range(9) < 7 ? gait_item() : noise_item());
        // hold off once per phase until the pipeline empties
        if (n == 100) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
